// ----- rtl/pimr_pkg.sv -----
// shared types and constants for the point-in-mesh ray parity core
package pimr_pkg;

   localparam int CoordWidth = 24;
   localparam int CoordFrac  = 12;
   localparam int DirFrac    = 30;

   // edge and offset components, one bit of growth
   localparam int EdgeWidth  = CoordWidth + 1;
   // cross product components
   localparam int CrossWidth = 2 * EdgeWidth + 1;
   // ray projections: cross times direction, three terms summed
   localparam int DotWidth   = CrossWidth + DirFrac + 3;
   // t: edge times cross, three terms summed
   localparam int TWidth     = EdgeWidth + CrossWidth + 2;
   // low part of a cross component in the split t products
   localparam int QSplit     = 26;
   // eps times det
   localparam int EpsWidth   = 17;
   localparam int LimWidth   = DotWidth + EpsWidth + 1;
   localparam int LimShift   = 40 + DirFrac - CoordFrac;
   localparam int DetShiftK  = 2 * CoordFrac + DirFrac;

   localparam logic [EpsWidth-1:0] EpsQ40 = 17'd109951;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   typedef logic signed [EdgeWidth-1:0]  edge_type;
   typedef logic signed [CrossWidth-1:0] cross_type;
   typedef logic [DirFrac:0]             dir_type;

   // one entry of the front-to-back queue: the three cross products, e2 and the last flag
   typedef struct packed {
      cross_type [2:0] n;
      cross_type [2:0] m;
      cross_type [2:0] q;
      edge_type  [2:0] e2;
      logic            last;
   } tri_type;

   // small direction components at 30 fraction bits, rounded half up below
   function automatic dir_type dir_q(input logic [31:0] raw30);
      logic [32:0] r;
      begin
         r = {1'b0, raw30} + ((33'd1 << (30 - DirFrac)) >> 1);
         dir_q = dir_type'(r >> (30 - DirFrac));
      end
   endfunction

   function automatic dir_type dir_comp(input logic [1:0] ray, input logic [1:0] axis);
      dir_type one;
      begin
         one = dir_type'(1) << DirFrac;
         dir_comp = one;
         if (ray != axis) begin
            case ({ray, axis})
               4'b0001: dir_comp = dir_q(32'd139586);
               4'b0010: dir_comp = dir_q(32'd182536);
               4'b0100: dir_comp = dir_q(32'd118112);
               4'b0110: dir_comp = dir_q(32'd204011);
               4'b1000: dir_comp = dir_q(32'd161061);
               4'b1001: dir_comp = dir_q(32'd246961);
               default: dir_comp = one;
            endcase
         end
      end
   endfunction

endpackage

// ----- rtl/pimr_front.sv -----
// front end: edges, offsets and cross products of one triangle
module pimr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [pimr_pkg::CoordWidth-1:0] px,
   input  logic signed [pimr_pkg::CoordWidth-1:0] py,
   input  logic signed [pimr_pkg::CoordWidth-1:0] pz,
   input  logic signed [pimr_pkg::CoordWidth-1:0] v0 [3],
   input  logic signed [pimr_pkg::CoordWidth-1:0] v1 [3],
   input  logic signed [pimr_pkg::CoordWidth-1:0] v2 [3],
   input  logic                            in_last,
   output logic                            out_valid,
   output pimr_pkg::tri_type               out_tri
);
   import pimr_pkg::*;

   edge_type e1_ff [3], e2_ff [3], s_ff [3];
   edge_type e1_in [3], e2_in [3], s_in [3];
   logic     v1_ff, last_ff;
   tri_type  tri_ff, tri_in;
   logic     v2_ff;

   always_comb begin
      e1_in[0] = edge_type'(v1[0]) - edge_type'(v0[0]);
      e1_in[1] = edge_type'(v1[1]) - edge_type'(v0[1]);
      e1_in[2] = edge_type'(v1[2]) - edge_type'(v0[2]);
      e2_in[0] = edge_type'(v2[0]) - edge_type'(v0[0]);
      e2_in[1] = edge_type'(v2[1]) - edge_type'(v0[1]);
      e2_in[2] = edge_type'(v2[2]) - edge_type'(v0[2]);
      s_in[0]  = edge_type'(px) - edge_type'(v0[0]);
      s_in[1]  = edge_type'(py) - edge_type'(v0[1]);
      s_in[2]  = edge_type'(pz) - edge_type'(v0[2]);
   end

   function automatic cross_type xc(input edge_type a1, input edge_type b2,
                                    input edge_type a2, input edge_type b1);
      xc = cross_type'(a1) * cross_type'(b2) - cross_type'(a2) * cross_type'(b1);
   endfunction

   always_comb begin
      tri_in.n[0] = xc(e2_ff[1], e1_ff[2], e2_ff[2], e1_ff[1]);
      tri_in.n[1] = xc(e2_ff[2], e1_ff[0], e2_ff[0], e1_ff[2]);
      tri_in.n[2] = xc(e2_ff[0], e1_ff[1], e2_ff[1], e1_ff[0]);
      tri_in.m[0] = xc(e2_ff[1], s_ff[2], e2_ff[2], s_ff[1]);
      tri_in.m[1] = xc(e2_ff[2], s_ff[0], e2_ff[0], s_ff[2]);
      tri_in.m[2] = xc(e2_ff[0], s_ff[1], e2_ff[1], s_ff[0]);
      tri_in.q[0] = xc(s_ff[1], e1_ff[2], s_ff[2], e1_ff[1]);
      tri_in.q[1] = xc(s_ff[2], e1_ff[0], s_ff[0], e1_ff[2]);
      tri_in.q[2] = xc(s_ff[0], e1_ff[1], s_ff[1], e1_ff[0]);
      tri_in.e2[0] = e2_ff[0];
      tri_in.e2[1] = e2_ff[1];
      tri_in.e2[2] = e2_ff[2];
      tri_in.last  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      s_ff    <= s_in;
      last_ff <= in_last;
      tri_ff  <= tri_in;
   end

   assign out_valid = v2_ff;
   assign out_tri   = tri_ff;

endmodule

// ----- rtl/pimr_queue.sv -----
// short queue between front and back ends
module pimr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  pimr_pkg::tri_type wr_data,
   input  logic              rd_en,
   output pimr_pkg::tri_type rd_data,
   output logic              not_empty,
   output logic [pimr_pkg::QueueAw:0] count
);
   import pimr_pkg::*;

   tri_type              mem [QueueDepth];
   logic [QueueAw-1:0]   wp_ff, rp_ff;
   logic [QueueAw:0]     cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QueueAw+1)'(wr_en) - (QueueAw+1)'(rd_en);
      end
      if (wr_en) mem[wp_ff] <= wr_data;
   end

   assign rd_data   = mem[rp_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (!(rd_en && cnt_ff == '0)) else $error("queue underflow");
         assert (!(wr_en && !rd_en && cnt_ff == (QueueAw+1)'(QueueDepth)))
            else $error("queue overflow");
      end
   end

   property p_count_step;
      @(posedge clock) disable iff (reset) (wr_en && !rd_en) |=> cnt_ff == $past(cnt_ff) + 1'b1;
   endproperty
   a_count_step: assert property (p_count_step) else $error("count step wrong");

endmodule

// ----- rtl/pimr_back.sv -----
// back end: per-ray projections, hit tests, parity and vote
module pimr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pimr_pkg::tri_type in_tri,
   output logic              res_valid,
   output logic [3:0]        res_bits
);
   import pimr_pkg::*;

   typedef logic signed [DotWidth-1:0] dot_type;
   typedef logic signed [TWidth-1:0]   t_type;
   typedef logic signed [LimWidth-1:0] lim_type;
   typedef logic signed [EdgeWidth+QSplit:0]              plo_type;
   typedef logic signed [EdgeWidth+CrossWidth-QSplit-1:0] phi_type;

   // stage 1: products of cross components and direction components
   dot_type pn_ff [3][3], pm_ff [3][3], pq_ff [3][3];
   // e2 times q, q split in a low and a high part
   plo_type plo_ff [3];
   phi_type phi_ff [3];
   logic    s1_v_ff, s1_last_ff;
   // stage 2: sums, sign folded
   dot_type det_ff [3], u_ff [3], v_ff [3];
   t_type   t_ff [3];
   logic    s2_v_ff, s2_last_ff;
   // stage 3: eps limit and range checks
   lim_type lim_ff [3];
   logic    pre_ok_ff [3];
   t_type   t3_ff [3];
   logic    s3_v_ff, s3_last_ff;
   logic [2:0] par_ff, hit_in;
   logic       rv_ff;
   logic [3:0] rb_ff;

   function automatic dot_type pmul(input cross_type c, input dir_type d);
      pmul = dot_type'(c) * dot_type'($signed({1'b0, d}));
   endfunction

   function automatic plo_type lo_mul(input edge_type e, input logic [QSplit-1:0] ql);
      lo_mul = plo_type'(e) * plo_type'($signed({1'b0, ql}));
   endfunction

   function automatic phi_type hi_mul(input edge_type e,
                                      input logic signed [CrossWidth-QSplit-1:0] qh);
      hi_mul = phi_type'(e) * phi_type'(qh);
   endfunction

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int a = 0; a < 3; a++) begin
            pn_ff[r][a] <= pmul(in_tri.n[a], dir_comp(2'(r), 2'(a)));
            pm_ff[r][a] <= pmul(in_tri.m[a], dir_comp(2'(r), 2'(a)));
            pq_ff[r][a] <= pmul(in_tri.q[a], dir_comp(2'(r), 2'(a)));
         end
         plo_ff[r] <= lo_mul(in_tri.e2[r], in_tri.q[r][QSplit-1:0]);
         phi_ff[r] <= hi_mul(in_tri.e2[r], $signed(in_tri.q[r][CrossWidth-1:QSplit]));
      end
      s1_last_ff <= in_tri.last;
   end

   always_ff @(posedge clock) begin
      dot_type dn, du, dv;
      t_type   tt;
      tt = '0;
      for (int a = 0; a < 3; a++)
         tt = tt + (t_type'(phi_ff[a]) <<< QSplit) + t_type'(plo_ff[a]);
      for (int r = 0; r < 3; r++) begin
         dn = pn_ff[r][0] + pn_ff[r][1] + pn_ff[r][2];
         du = pm_ff[r][0] + pm_ff[r][1] + pm_ff[r][2];
         dv = pq_ff[r][0] + pq_ff[r][1] + pq_ff[r][2];
         if (dn < 0) begin
            det_ff[r] <= -dn; u_ff[r] <= -du; v_ff[r] <= -dv; t_ff[r] <= -tt;
         end else begin
            det_ff[r] <= dn;  u_ff[r] <= du;  v_ff[r] <= dv;  t_ff[r] <= tt;
         end
      end
      s2_last_ff <= s1_last_ff;
   end

   always_ff @(posedge clock) begin
      logic signed [LimWidth:0] lhs, rhs;
      for (int r = 0; r < 3; r++) begin
         lim_ff[r] <= lim_type'((lim_type'(det_ff[r]) * lim_type'({1'b0, EpsQ40}))
                      >>> LimShift);
         if (DetShiftK < 40) begin
            lhs = (LimWidth+1)'(det_ff[r]) <<< (40 - DetShiftK);
            rhs = (LimWidth+1)'({1'b0, EpsQ40});
         end else begin
            lhs = (LimWidth+1)'(det_ff[r]);
            rhs = (LimWidth+1)'({1'b0, EpsQ40}) <<< (DetShiftK - 40);
         end
         pre_ok_ff[r] <= !(lhs < rhs) && !(u_ff[r] < 0) && !(det_ff[r] < u_ff[r])
                         && !(v_ff[r] < 0)
                         && !((LimWidth+1)'(det_ff[r]) <
                              (LimWidth+1)'(u_ff[r]) + (LimWidth+1)'(v_ff[r]));
         t3_ff[r] <= t_ff[r];
      end
      s3_last_ff <= s2_last_ff;
   end

   always_comb begin
      for (int r = 0; r < 3; r++)
         hit_in[r] = pre_ok_ff[r] && (lim_ff[r] < lim_type'(t3_ff[r]));
   end

   always_ff @(posedge clock) begin
      logic [2:0] np;
      if (reset) begin
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0; s3_v_ff <= 1'b0;
         par_ff  <= '0;   rv_ff   <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         rv_ff   <= s3_v_ff && s3_last_ff;
         if (s3_v_ff) begin
            np = par_ff ^ hit_in;
            par_ff <= s3_last_ff ? 3'b000 : np;
         end
      end
      np = par_ff ^ hit_in;
      rb_ff <= {(np[0] & np[1]) | (np[0] & np[2]) | (np[1] & np[2]), np};
   end

   assign res_valid = rv_ff;
   assign res_bits  = rb_ff;

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && s3_last_ff) |=> par_ff == 3'b000) else $error("parity not cleared");
   a_res: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> $past(s3_v_ff)) else $error("result without item");
   a_vote: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (res_bits[3] == ($countones(res_bits[2:0]) >= 2)))
      else $error("vote mismatch");

endmodule

// ----- rtl/point_in_mesh_ray_parity_core.sv -----
// top level of the point-in-mesh ray parity core
//
//  channel   handshake          payload
//  req       push / full        vertex0..2 xyz, last_triangle
//  rsp       empty / pop        inside_res, x/y/z_ray_odd
//  csr       csr_we             csr_index, csr_wdata
//
// a triangle is accepted in a cycle with push high and full low; the result of the last
// accepted triangle reaches the rsp ports through its path (2 front stages, queue,
// 4 back stages, result buffer)
// the back end drains the queue one triangle per cycle
// full rises while three last-triangle requests are in flight or parked
// reset clears point registers, parities, queue and result buffer
module point_in_mesh_ray_parity_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex0_x,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex0_y,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex0_z,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex1_x,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex1_y,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex1_z,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex2_x,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex2_y,
   input  logic signed [pimr_pkg::CoordWidth-1:0] req_vertex2_z,
   input  logic        req_last_triangle,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_inside_res,
   output logic        rsp_x_ray_odd,
   output logic        rsp_y_ray_odd,
   output logic        rsp_z_ray_odd,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [pimr_pkg::CoordWidth-1:0] csr_wdata
);
   import pimr_pkg::*;

   localparam logic [1:0] RegPointX = 2'd0;
   localparam logic [1:0] RegPointY = 2'd1;
   localparam logic [1:0] RegPointZ = 2'd2;

   logic signed [CoordWidth-1:0] px_ff, py_ff, pz_ff;
   logic signed [CoordWidth-1:0] v0 [3], v1 [3], v2 [3];
   logic        accept, f_valid, q_ne, res_valid;
   tri_type     f_tri, q_tri;
   logic [QueueAw:0] q_cnt;
   logic [3:0]  res_bits;
   // result buffer: back end runs freely, so results park here
   logic [3:0]  rbuf_ff [4];
   logic [1:0]  rwp_ff, rrp_ff;
   logic [2:0]  rcnt_ff;
   logic [2:0]  inflight_ff;
   logic        pop_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0; py_ff <= '0; pz_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            RegPointX: px_ff <= csr_wdata;
            RegPointY: py_ff <= csr_wdata;
            RegPointZ: pz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign v0[0] = req_vertex0_x; assign v0[1] = req_vertex0_y; assign v0[2] = req_vertex0_z;
   assign v1[0] = req_vertex1_x; assign v1[1] = req_vertex1_y; assign v1[2] = req_vertex1_z;
   assign v2[0] = req_vertex2_x; assign v2[1] = req_vertex2_y; assign v2[2] = req_vertex2_z;

   // last-triangle requests in flight bound the result buffer
   assign full   = (inflight_ff + rcnt_ff) >= 3'd3;
   assign accept = push && !full;
   assign pop_ok = pop && !empty;

   pimr_front u_front (
      .clock, .reset, .in_valid(accept), .px(px_ff), .py(py_ff), .pz(pz_ff),
      .v0, .v1, .v2, .in_last(req_last_triangle),
      .out_valid(f_valid), .out_tri(f_tri)
   );

   // queue drains each cycle, so it never holds more than one entry
   pimr_queue u_queue (
      .clock, .reset, .wr_en(f_valid), .wr_data(f_tri),
      .rd_en(q_ne), .rd_data(q_tri), .not_empty(q_ne), .count(q_cnt)
   );

   pimr_back u_back (
      .clock, .reset, .in_valid(q_ne), .in_tri(q_tri),
      .res_valid, .res_bits
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0; rwp_ff <= '0; rrp_ff <= '0; rcnt_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + 3'(accept && req_last_triangle) - 3'(res_valid);
         if (res_valid) rwp_ff <= rwp_ff + 1'b1;
         if (pop_ok)    rrp_ff <= rrp_ff + 1'b1;
         rcnt_ff <= rcnt_ff + 3'(res_valid) - 3'(pop_ok);
      end
      if (res_valid) rbuf_ff[rwp_ff] <= res_bits;
   end

   assign empty          = (rcnt_ff == '0);
   assign rsp_inside_res = rbuf_ff[rrp_ff][3];
   assign rsp_x_ray_odd  = rbuf_ff[rrp_ff][0];
   assign rsp_y_ray_odd  = rbuf_ff[rrp_ff][1];
   assign rsp_z_ray_odd  = rbuf_ff[rrp_ff][2];

   a_qdepth: assert property (@(posedge clock) disable iff (reset) q_cnt <= 3'd1)
      else $error("queue backed up");
   a_room: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff + rcnt_ff) <= 3'd3) else $error("result buffer overrun");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rcnt_ff == '0 && !res_valid) |=> empty) else $error("empty mismatch");

endmodule

// ----- test/point_in_mesh_ray_parity_core_chk.sv -----
// checker for the point-in-mesh ray parity core: prediction and comparison
`timescale 1ns / 100ps

module point_in_mesh_ray_parity_core_chk
   import pimr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [23:0] req_vertex0_x,
   input  logic [23:0] req_vertex0_y,
   input  logic [23:0] req_vertex0_z,
   input  logic [23:0] req_vertex1_x,
   input  logic [23:0] req_vertex1_y,
   input  logic [23:0] req_vertex1_z,
   input  logic [23:0] req_vertex2_x,
   input  logic [23:0] req_vertex2_y,
   input  logic [23:0] req_vertex2_z,
   input  logic        req_last_triangle,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_inside_res,
   input  logic        rsp_x_ray_odd,
   input  logic        rsp_y_ray_odd,
   input  logic        rsp_z_ray_odd,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          errors,
   output int          pending,
   output int          verdicts
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic in_mesh;
      logic x_odd;
      logic y_odd;
      logic z_odd;
   } verdict_type;

   localparam logic [1:0] IdxPointX = 2'd0;
   localparam logic [1:0] IdxPointY = 2'd1;
   localparam logic [1:0] IdxPointZ = 2'd2;

   verdict_type verdict_q[$];
   logic [23:0] pt_x, pt_y, pt_z;
   logic [2:0]  parity;

   function automatic wide_type sx(input logic [23:0] c);
      return wide_type'($signed(c));
   endfunction

   // small direction components rounded half up from 30 fraction bits
   function automatic wide_type dir_small(input longint raw30);
      longint sh;
      sh = 30 - DirFrac;
      return wide_type'((raw30 + ((64'd1 << sh) >> 1)) >> sh);
   endfunction

   function automatic wide_type dir_of(input int r, input int a);
      if (r == a) return wide_type'(1) << DirFrac;
      case (r * 3 + a)
         1: return dir_small(139586);
         2: return dir_small(182536);
         3: return dir_small(118112);
         5: return dir_small(204011);
         6: return dir_small(161061);
         default: return dir_small(246961);
      endcase
   endfunction

   function automatic wide_type dot3(input wide_type a0, a1, a2, b0, b1, b2);
      return a0 * b0 + a1 * b1 + a2 * b2;
   endfunction

   // division-free crossing test along one ray
   function automatic logic ray_crosses(input int r, input wide_type n[3],
                                        input wide_type m[3], input wide_type q[3],
                                        input wide_type e2[3]);
      wide_type d0, d1, d2, det, u, v, t, lhs, rhs, lim;
      int       k;
      d0 = dir_of(r, 0);
      d1 = dir_of(r, 1);
      d2 = dir_of(r, 2);
      k = 2 * CoordFrac + DirFrac;
      det = dot3(d0, d1, d2, n[0], n[1], n[2]);
      u = dot3(d0, d1, d2, m[0], m[1], m[2]);
      v = dot3(d0, d1, d2, q[0], q[1], q[2]);
      t = dot3(e2[0], e2[1], e2[2], q[0], q[1], q[2]);
      if (det < 0) begin
         det = -det; u = -u; v = -v; t = -t;
      end
      lhs = (k < 40) ? det <<< (40 - k) : det;
      rhs = (k > 40) ? wide_type'(EpsQ40) <<< (k - 40) : wide_type'(EpsQ40);
      if (lhs < rhs) return 1'b0;
      if (u < 0 || det < u) return 1'b0;
      if (v < 0 || det < u + v) return 1'b0;
      lim = (det * wide_type'(EpsQ40)) >>> (40 + DirFrac - CoordFrac);
      return lim < t;
   endfunction

   function automatic logic [2:0] crossings();
      wide_type v0[3], e1[3], e2[3], s[3], n[3], m[3], q[3];
      logic [2:0] h;
      v0[0] = sx(req_vertex0_x); v0[1] = sx(req_vertex0_y); v0[2] = sx(req_vertex0_z);
      e1[0] = sx(req_vertex1_x) - v0[0];
      e1[1] = sx(req_vertex1_y) - v0[1];
      e1[2] = sx(req_vertex1_z) - v0[2];
      e2[0] = sx(req_vertex2_x) - v0[0];
      e2[1] = sx(req_vertex2_y) - v0[1];
      e2[2] = sx(req_vertex2_z) - v0[2];
      s[0] = sx(pt_x) - v0[0]; s[1] = sx(pt_y) - v0[1]; s[2] = sx(pt_z) - v0[2];
      n[0] = e2[1] * e1[2] - e2[2] * e1[1];
      n[1] = e2[2] * e1[0] - e2[0] * e1[2];
      n[2] = e2[0] * e1[1] - e2[1] * e1[0];
      m[0] = e2[1] * s[2] - e2[2] * s[1];
      m[1] = e2[2] * s[0] - e2[0] * s[2];
      m[2] = e2[0] * s[1] - e2[1] * s[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      for (int r = 0; r < 3; r++) h[r] = ray_crosses(r, n, m, q, e2);
      return h;
   endfunction

   always @(posedge clock) begin
      logic [2:0]  p;
      verdict_type want;
      if (reset) begin
         pt_x <= '0; pt_y <= '0; pt_z <= '0;
         parity <= '0;
         verdict_q.delete();
         errors <= 0;
         verdicts <= 0;
         pending <= 0;
      end else begin
         if (pop && !empty) begin
            verdicts <= verdicts + 1;
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected verdict inside=%b x=%b y=%b z=%b", $time,
                        rsp_inside_res, rsp_x_ray_odd, rsp_y_ray_odd, rsp_z_ray_odd);
               errors <= errors + 1;
            end else begin
               want = verdict_q.pop_front();
               if (want != {rsp_inside_res, rsp_x_ray_odd, rsp_y_ray_odd, rsp_z_ray_odd}) begin
                  $display("%0t: verdict mismatch expected inside=%b x=%b y=%b z=%b, %s",
                           $time, want.in_mesh, want.x_odd, want.y_odd, want.z_odd,
                           $sformatf("got %b %b %b %b", rsp_inside_res, rsp_x_ray_odd,
                                     rsp_y_ray_odd, rsp_z_ray_odd));
                  errors <= errors + 1;
               end
            end
         end
         if (push && !full) begin
            p = parity ^ crossings();
            if (req_last_triangle) begin
               want.in_mesh = (p[0] + p[1] + p[2]) >= 2;
               want.x_odd = p[0];
               want.y_odd = p[1];
               want.z_odd = p[2];
               verdict_q.insert(verdict_q.size(), want);
               parity <= '0;
            end else begin
               parity <= p;
            end
         end
         // point registers, unknown index ignored
         if (csr_we) begin
            case (csr_index)
               IdxPointX: pt_x <= csr_wdata;
               IdxPointY: pt_y <= csr_wdata;
               IdxPointZ: pt_z <= csr_wdata;
               default: ;
            endcase
         end
         pending <= verdict_q.size();
      end
   end

endmodule

// ----- test/point_in_mesh_ray_parity_core_tb.sv -----
// top of the point-in-mesh ray parity core testbench: stimulus and verdict
`timescale 1ns / 100ps

module point_in_mesh_ray_parity_core_tb;

   localparam int NumTriangles = 900;
   localparam int StallLimit   = 5000;
   localparam int DrainCycles  = 20;

   localparam logic [1:0] IdxPointX  = 2'd0;
   localparam logic [1:0] IdxPointY  = 2'd1;
   localparam logic [1:0] IdxPointZ  = 2'd2;
   localparam logic [1:0] IdxUnknown = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [23:0] v0x = '0, v0y = '0, v0z = '0;
   logic [23:0] v1x = '0, v1y = '0, v1z = '0;
   logic [23:0] v2x = '0, v2y = '0, v2z = '0;
   logic        last_tri = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_inside_res, rsp_x_ray_odd, rsp_y_ray_odd, rsp_z_ray_odd;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   int          errors, pending, verdicts;
   int          sent = 0;
   int          phases = 0;
   int          idle_cycles = 0;
   logic        quiet = 1'b0;      // no idling in the last part of the run
   logic        hold_done = 1'b0;  // long receiver hold-off already done
   logic [23:0] px = '0, py = '0, pz = '0;

   always #4 clock = ~clock;

   point_in_mesh_ray_parity_core dut (
      .clock, .reset, .push, .full,
      .req_vertex0_x(v0x), .req_vertex0_y(v0y), .req_vertex0_z(v0z),
      .req_vertex1_x(v1x), .req_vertex1_y(v1y), .req_vertex1_z(v1z),
      .req_vertex2_x(v2x), .req_vertex2_y(v2y), .req_vertex2_z(v2z),
      .req_last_triangle(last_tri),
      .empty, .pop,
      .rsp_inside_res, .rsp_x_ray_odd, .rsp_y_ray_odd, .rsp_z_ray_odd,
      .csr_we, .csr_index, .csr_wdata
   );

   point_in_mesh_ray_parity_core_chk chk (
      .clock, .reset, .push, .full,
      .req_vertex0_x(v0x), .req_vertex0_y(v0y), .req_vertex0_z(v0z),
      .req_vertex1_x(v1x), .req_vertex1_y(v1y), .req_vertex1_z(v1z),
      .req_vertex2_x(v2x), .req_vertex2_y(v2y), .req_vertex2_z(v2z),
      .req_last_triangle(last_tri),
      .empty, .pop,
      .rsp_inside_res, .rsp_x_ray_odd, .rsp_y_ray_odd, .rsp_z_ray_odd,
      .csr_we, .csr_index, .csr_wdata,
      .errors, .pending, .verdicts
   );

   // watchdog: cycles with no request or verdict accepted
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("point_in_mesh_ray_parity_core_tb NOT OK");
            $finish;
         end
      end
   end

   // receiver: random pop bursts, one long hold-off to back the block up
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (quiet) begin
            pop <= 1'b1;
            @(posedge clock);
         end else if (!hold_done && sent > 300) begin
            pop <= 1'b0;
            hold_done = 1'b1;
            repeat (400) @(posedge clock);
         end else begin
            n = $urandom_range(1, 15);
            pop <= $urandom_range(0, 2) != 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // offer one triangle and wait until it is taken
   task automatic send_tri(input logic [23:0] a[9], input logic lst);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      {v0x, v0y, v0z} <= {a[0], a[1], a[2]};
      {v1x, v1y, v1z} <= {a[3], a[4], a[5]};
      {v2x, v2y, v2z} <= {a[6], a[7], a[8]};
      last_tri <= lst;
      push <= 1'b1;
      do @(posedge clock); while (full);
      sent++;
   endtask

   // wait until every verdict is in and the back end has drained
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_point(input logic [23:0] x, y, z);
      phases++;
      csr_we <= 1'b1;
      csr_index <= IdxPointX; csr_wdata <= x; @(posedge clock);
      csr_index <= IdxPointY; csr_wdata <= y; @(posedge clock);
      csr_index <= IdxPointZ; csr_wdata <= z; @(posedge clock);
      csr_we <= 1'b0;
      px = x; py = y; pz = z;
   endtask

   // coordinate near the point, wrapping in 24 bits
   function automatic logic [23:0] near(input logic [23:0] c, input int span);
      return c + 24'($urandom_range(0, 2 * span)) - 24'(span);
   endfunction

   task automatic one_mesh();
      logic [23:0] a[9];
      int          len, span;
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: full-range vertices
            for (int k = 0; k < 9; k++) a[k] = 24'($urandom());
         end else begin
            span = 1 << $urandom_range(6, 21);
            for (int k = 0; k < 9; k += 3) begin
               a[k] = near(px, span);
               a[k + 1] = near(py, span);
               a[k + 2] = near(pz, span);
            end
         end
         send_tri(a, i == len - 1);
      end
   endtask

   initial begin
      logic [23:0] a[9];
      logic [23:0] pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unknown register index, point at origin
      csr_we <= 1'b1; csr_index <= IdxUnknown; csr_wdata <= 24'hFFFFFF;
      @(posedge clock);
      set_point(24'd0, 24'd0, 24'd0);

      // last with nothing before: degenerate triangle, no crossing
      a = '{default: 24'd0};
      send_tri(a, 1'b1);
      // triangles straddling each ray, one behind the point
      a = '{24'd1000, -24'd5000, -24'd5000, 24'd1000, 24'd10000, -24'd5000,
            24'd1000, -24'd5000, 24'd10000};
      send_tri(a, 1'b0);
      a = '{-24'd5000, 24'd1000, -24'd5000, 24'd10000, 24'd1000, -24'd5000,
            -24'd5000, 24'd1000, 24'd10000};
      send_tri(a, 1'b0);
      a = '{-24'd5000, -24'd5000, 24'd1000, 24'd10000, -24'd5000, 24'd1000,
            -24'd5000, 24'd10000, 24'd1000};
      send_tri(a, 1'b1);
      a = '{-24'd1000, -24'd5000, -24'd5000, -24'd1000, 24'd10000, -24'd5000,
            -24'd1000, -24'd5000, 24'd10000};
      send_tri(a, 1'b1);
      // edge-on triangle, then field extremes
      a = '{24'd0, 24'd0, 24'd0, 24'd100, 24'd100, 24'd100, 24'd200, 24'd200, 24'd200};
      send_tri(a, 1'b0);
      a = '{default: 24'h7FFFFF};
      send_tri(a, 1'b0);
      a = '{default: 24'h800000};
      send_tri(a, 1'b0);
      a = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
            24'h800000, 24'h800000, 24'h7FFFFF};
      send_tri(a, 1'b1);
      settle();
      set_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      a = '{24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
            24'h7FFFFF, 24'h7FFFFF, 24'h800000};
      send_tri(a, 1'b1);
      settle();

      // random meshes in phases, point changed between phases
      while (sent < NumTriangles) begin
         case ($urandom_range(0, 3))
            0: pick = 24'h7FFFFF;
            1: pick = 24'h800000;
            default: pick = 24'($urandom());
         endcase
         set_point(pick, 24'($urandom()), $urandom_range(0, 1) ? 24'($urandom()) : 24'd0);
         for (int j = 0; j < 12 && sent < NumTriangles; j++) begin
            if (sent > NumTriangles * 4 / 5) quiet = 1'b1;
            one_mesh();
         end
         settle();
      end

      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d triangles over %0d point settings, %0d verdicts checked",
               sent, phases, verdicts);
      if (errors == 0 && pending == 0) begin
         $display("point_in_mesh_ray_parity_core_tb OK");
      end else begin
         $display("point_in_mesh_ray_parity_core_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pimr_pkg.sv
rtl/pimr_front.sv
rtl/pimr_queue.sv
rtl/pimr_back.sv
rtl/point_in_mesh_ray_parity_core.sv
test/point_in_mesh_ray_parity_core_chk.sv
test/point_in_mesh_ray_parity_core_tb.sv
